/* sv/sssv_pkg.sv */
// sssv_pkg: shared types and constants of the stepper speed and stall supervisor
// holds item, configuration, memory word and pipeline stage types
// no dependencies
package sssv_pkg;

  // default motor count and its limits
  localparam int unsigned MOTOR_COUNT_DEF = 5;
  localparam int unsigned MOTOR_COUNT_MAX = 16;

  // field widths fixed by the interface
  localparam int unsigned IDX_FIELD_W = 3;
  localparam int unsigned SPEED_W     = 32;
  localparam int unsigned FREQ_W      = 24;
  localparam int unsigned LOCK_W      = 8;
  localparam int unsigned STOP_W      = 4;
  localparam int unsigned TIMER_W     = 16;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // arithmetic widths
  localparam int unsigned RAW_PROD_W  = 64;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned FPROD_W     = 48;
  localparam int unsigned PIPE_DEPTH  = 4;

  // configuration reset values
  localparam logic [15:0] STEPS_PER_UNIT_RST = 16'd12800;
  localparam logic [31:0] SPEED_SCALE_RST    = 32'd65536;
  localparam logic [8:0]  FILTER_KEEP_RST    = 9'd230;
  localparam logic        LOCK_ENABLE_RST    = 1'b1;
  localparam logic [7:0]  LOCK_LIMIT_RST     = 8'd100;
  localparam logic [3:0]  STOP_LIMIT_RST     = 4'd10;
  localparam logic [15:0] CLEAR_PERIOD_RST   = 16'd1500;

  // full filter weight, one in 1/256 units
  localparam logic [8:0]  FILTER_ONE = 9'd256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEPS_PER_UNIT = 3'd0,
    REG_SPEED_SCALE    = 3'd1,
    REG_FILTER_KEEP    = 3'd2,
    REG_LOCK_ENABLE    = 3'd3,
    REG_LOCK_LIMIT     = 3'd4,
    REG_STOP_LIMIT     = 3'd5,
    REG_CLEAR_PERIOD   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] steps_per_unit;
    logic [31:0] speed_scale;
    logic [8:0]  filter_keep;
    logic        lock_enable;
    logic [7:0]  lock_limit;
    logic [3:0]  stop_limit;
    logic [15:0] clear_period;
  } cfg_t;

  // one input transaction
  typedef struct packed {
    logic [IDX_FIELD_W-1:0]    motor_index;
    logic signed [SPEED_W-1:0] position;
    logic signed [SPEED_W-1:0] commanded_speed;
    logic                      run_active;
    logic                      last_of_tick;
    logic                      clear_locks;
  } item_t;

  // per-motor word in the state memory
  typedef struct packed {
    logic signed [SPEED_W-1:0] position;
    logic signed [SPEED_W-1:0] filtered;
    logic signed [SPEED_W-1:0] applied;
  } mem_word_t;

  // item context carried through the pipeline
  typedef struct packed {
    item_t                     item;
    logic                      in_range;
    logic signed [SPEED_W-1:0] filt_old;
    logic signed [SPEED_W-1:0] applied;
  } ctx_t;

  // last stage contents handed to the commit logic
  typedef struct packed {
    ctx_t                      ctx;
    logic signed [SUM_W-1:0]   sum;
    logic [FPROD_W-1:0]        fprod;
  } s4_t;

  // pipeline occupancy seen by the interlock
  typedef struct packed {
    logic                                    ready;
    logic [PIPE_DEPTH-1:0]                   busy;
    logic [PIPE_DEPTH-1:0][IDX_FIELD_W-1:0]  motor;
  } pipe_stat_t;

endpackage

/* sv/sssv_meas_pipe.sv */
// sssv_meas_pipe: speed measurement pipeline, position delta, scaling,
// saturation, step frequency product and filter sum over four stages
// depends on sssv_pkg
module sssv_meas_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sssv_pkg::cfg_t         cfg_i,
  input  logic                   push_i,
  input  sssv_pkg::item_t        item_i,
  input  logic                   in_range_i,
  input  sssv_pkg::mem_word_t    rd_word_i,
  input  logic                   pop_i,
  output sssv_pkg::pipe_stat_t   stat_o,
  output sssv_pkg::s4_t          s4_o
);
  import sssv_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  ctx_t ctx1_q, ctx2_q, ctx3_q;
  s4_t  s4_q;

  logic signed [RAW_PROD_W-1:0] prod_q;
  logic signed [SPEED_W-1:0]    raw_q;
  logic [FPROD_W-1:0]           fprod3_q;

  logic signed [SPEED_W-1:0]    delta;
  logic signed [RAW_PROD_W:0]   prod_full;
  logic signed [SPEED_W-1:0]    raw_d;
  logic [SPEED_W-1:0]           mag;
  logic [FPROD_W-1:0]           fprod_d;
  logic [8:0]                   keep;
  logic [8:0]                   keep_new;
  logic signed [SUM_W-1:0]      sum_d;
  ctx_t                         ctx2_d;

  // stage enables, a stage moves when the next one is free or moving
  assign en4 = !v4_q || pop_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= push_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: memory word arrives, position delta times speed scale
  always_comb begin
    ctx2_d          = ctx1_q;
    ctx2_d.filt_old = rd_word_i.filtered;
    ctx2_d.applied  = rd_word_i.applied;
  end

  assign delta     = ctx1_q.item.position - rd_word_i.position;
  assign prod_full = $signed(delta) * $signed({1'b0, cfg_i.speed_scale});

  // stage 2: saturate raw speed, commanded magnitude times steps per unit
  always_comb begin
    if (prod_q[RAW_PROD_W-1:SPEED_W-1] != '0 && prod_q[RAW_PROD_W-1:SPEED_W-1] != '1) begin
      raw_d = prod_q[RAW_PROD_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
    end else begin
      raw_d = prod_q[SPEED_W-1:0];
    end
  end

  assign mag     = ctx2_q.item.commanded_speed[SPEED_W-1] ?
                   (~ctx2_q.item.commanded_speed + 1'b1) : ctx2_q.item.commanded_speed;
  assign fprod_d = {16'b0, mag} * {32'b0, cfg_i.steps_per_unit};

  // stage 3: first-order filter sum, weight clamped to one
  assign keep     = (cfg_i.filter_keep > FILTER_ONE) ? FILTER_ONE : cfg_i.filter_keep;
  assign keep_new = FILTER_ONE - keep;
  assign sum_d    = $signed(ctx3_q.filt_old) * $signed({1'b0, keep})
                  + $signed(raw_q) * $signed({1'b0, keep_new});

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (en1 && push_i) begin
      ctx1_q.item     <= item_i;
      ctx1_q.in_range <= in_range_i;
      ctx1_q.filt_old <= '0;
      ctx1_q.applied  <= '0;
    end
    if (en2 && v1_q) begin
      ctx2_q <= ctx2_d;
      prod_q <= prod_full[RAW_PROD_W-1:0];
    end
    if (en3 && v2_q) begin
      ctx3_q   <= ctx2_q;
      raw_q    <= raw_d;
      fprod3_q <= fprod_d;
    end
    if (en4 && v3_q) begin
      s4_q.ctx   <= ctx3_q;
      s4_q.sum   <= sum_d;
      s4_q.fprod <= fprod3_q;
    end
  end

  // occupancy for the same-motor interlock
  assign stat_o.ready    = en1;
  assign stat_o.busy     = {v4_q, v3_q, v2_q, v1_q};
  assign stat_o.motor[0] = ctx1_q.item.motor_index;
  assign stat_o.motor[1] = ctx2_q.item.motor_index;
  assign stat_o.motor[2] = ctx3_q.item.motor_index;
  assign stat_o.motor[3] = s4_q.ctx.item.motor_index;
  assign s4_o            = s4_q;

endmodule

/* sv/stepper_speed_and_stall_supervisor.sv */
// stepper_speed_and_stall_supervisor: per-motor speed filter and stall supervisor
// top level with state memory, interlock, commit logic and output register
// depends on sssv_pkg and sssv_meas_pipe
//
// Usage: one input transaction per motor per control tick on in_valid_i /
// in_stall_o, one result transaction per in-range motor on out_valid_o /
// out_stall_i. Items with a motor index at or above MOTOR_COUNT give no result
// but still apply their lock clear request and advance the tick timer.
// The user must write registers on the cfg port (index, data) only while no item is in
// flight; the block itself does not enforce it. A result passes through the memory read,
// scale multiply, saturation and frequency multiply, filter sum and commit in that order.
// Throughput: one item per cycle when consecutive items name different motors and the
// result side does not stall. An item for a motor still in one of the four pipeline
// stages waits until that motor's read-modify-write of the state memory is done, so a
// new item for one motor alone is taken only once its previous item has committed.
// Reset: registers take their default values, all per-motor state reads as zero
// through per-entry valid bits, the tick timer clears. No clearing pass is needed.
// A stalled result stays in the output register; the pipeline keeps accepting
// until its four stages are full, then raises in_stall_o.
module stepper_speed_and_stall_supervisor #(
  parameter int unsigned MOTOR_COUNT = sssv_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sssv_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sssv_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sssv_pkg::IDX_FIELD_W-1:0]      motor_index_i,
  input  logic signed [sssv_pkg::SPEED_W-1:0]   position_i,
  input  logic signed [sssv_pkg::SPEED_W-1:0]   commanded_speed_i,
  input  logic                                  run_active_i,
  input  logic                                  last_of_tick_i,
  input  logic                                  clear_locks_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sssv_pkg::IDX_FIELD_W-1:0]      motor_out_o,
  output logic [sssv_pkg::FREQ_W-1:0]           step_frequency_o,
  output logic                                  direction_o,
  output logic                                  frequency_update_o,
  output logic                                  running_o,
  output logic                                  stalled_o,
  output logic                                  any_stalled_o,
  output logic signed [sssv_pkg::SPEED_W-1:0]   smoothed_speed_o
);
  import sssv_pkg::*;

  localparam int unsigned IDX_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int unsigned BASE_W = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
  localparam int unsigned EXT_W  = BASE_W + 1;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_unit <= STEPS_PER_UNIT_RST;
      cfg_q.speed_scale    <= SPEED_SCALE_RST;
      cfg_q.filter_keep    <= FILTER_KEEP_RST;
      cfg_q.lock_enable    <= LOCK_ENABLE_RST;
      cfg_q.lock_limit     <= LOCK_LIMIT_RST;
      cfg_q.stop_limit     <= STOP_LIMIT_RST;
      cfg_q.clear_period   <= CLEAR_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_STEPS_PER_UNIT: cfg_q.steps_per_unit <= cfg_data_i[15:0];
        REG_SPEED_SCALE:    cfg_q.speed_scale    <= cfg_data_i;
        REG_FILTER_KEEP:    cfg_q.filter_keep    <= cfg_data_i[8:0];
        REG_LOCK_ENABLE:    cfg_q.lock_enable    <= cfg_data_i[0];
        REG_LOCK_LIMIT:     cfg_q.lock_limit     <= cfg_data_i[7:0];
        REG_STOP_LIMIT:     cfg_q.stop_limit     <= cfg_data_i[3:0];
        REG_CLEAR_PERIOD:   cfg_q.clear_period   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input decode and interlock against motors still in flight
  item_t            in_item;
  logic [EXT_W-1:0] in_idx_ext;
  logic             in_range;
  logic             hazard;
  logic             accept;
  pipe_stat_t       stat;
  s4_t              s4;

  assign in_item.motor_index     = motor_index_i;
  assign in_item.position        = position_i;
  assign in_item.commanded_speed = commanded_speed_i;
  assign in_item.run_active      = run_active_i;
  assign in_item.last_of_tick    = last_of_tick_i;
  assign in_item.clear_locks     = clear_locks_i;

  assign in_idx_ext = EXT_W'(motor_index_i);
  assign in_range   = in_idx_ext < EXT_W'(MOTOR_COUNT);

  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      if (stat.busy[s] && stat.motor[s] == motor_index_i) hazard = 1'b1;
    end
  end

  assign in_stall_o = !stat.ready || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  // state memory, one word per motor, one read and one write port
  mem_word_t              mem [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] ent_valid_q;
  mem_word_t              rd_q;
  logic                   rd_valid_q;
  mem_word_t              rd_word;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [IDX_W-1:0]       wr_addr;
  mem_word_t              wr_word;

  assign rd_en   = accept && in_range;
  assign rd_addr = in_idx_ext[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_word;
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_valid_q <= ent_valid_q[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (mem_we) begin
      ent_valid_q[wr_addr] <= 1'b1;
    end
  end

  assign rd_word = rd_valid_q ? rd_q : '0;

  // measurement pipeline
  logic pop;

  sssv_meas_pipe u_meas_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (accept),
    .item_i     (in_item),
    .in_range_i (in_range),
    .rd_word_i  (rd_word),
    .pop_i      (pop),
    .stat_o     (stat),
    .s4_o       (s4)
  );

  // commit stage: stall check, applied speed, counters and timer
  logic [MOTOR_COUNT-1:0][LOCK_W-1:0] lock_q, lock_d;
  logic [MOTOR_COUNT-1:0][STOP_W-1:0] stop_q, stop_d;
  logic [MOTOR_COUNT-1:0]             stall_q, stall_d;
  logic [MOTOR_COUNT-1:0]             run_q, run_d;
  logic [TIMER_W-1:0]                 timer_q, timer_d;
  logic [TIMER_W-1:0]                 timer_inc;

  logic                      commit;
  logic                      load_out;
  logic [EXT_W-1:0]          c_idx_ext;
  logic [IDX_W-1:0]          c_addr;
  logic signed [SPEED_W-1:0] filt_new;
  logic signed [SPEED_W-1:0] cmd;
  logic signed [SPEED_W-1:0] applied_c;
  logic signed [SPEED_W-1:0] speed_c;
  logic [LOCK_W-1:0]         lock_c;
  logic [STOP_W-1:0]         stop_c;
  logic                      stall_c;
  logic                      run_c;
  logic                      opposing;
  logic                      update_c;
  logic [FPROD_W-1:0]        fprod_c;
  logic [FREQ_W-1:0]         freq_c;

  assign pop       = !out_valid_o || !out_stall_i;
  assign commit    = stat.busy[PIPE_DEPTH-1] && pop;
  assign load_out  = commit && s4.ctx.in_range;
  assign c_idx_ext = EXT_W'(s4.ctx.item.motor_index);
  assign c_addr    = c_idx_ext[IDX_W-1:0];
  assign filt_new  = s4.sum[SPEED_W+7:8];
  assign cmd       = s4.ctx.item.commanded_speed;
  assign opposing  = (!s4.ctx.applied[SPEED_W-1] && s4.ctx.applied != '0 && filt_new[SPEED_W-1])
                  || (s4.ctx.applied[SPEED_W-1] && !filt_new[SPEED_W-1] && filt_new != '0);
  assign timer_inc = timer_q + 1'b1;

  always_comb begin
    lock_d    = lock_q;
    stop_d    = stop_q;
    stall_d   = stall_q;
    run_d     = run_q;
    timer_d   = timer_q;
    lock_c    = '0;
    stop_c    = '0;
    stall_c   = 1'b0;
    run_c     = 1'b0;
    applied_c = s4.ctx.applied;
    speed_c   = '0;
    fprod_c   = '0;
    update_c  = 1'b0;
    if (commit) begin
      // clear request acts before this item
      if (s4.ctx.item.clear_locks) begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          lock_d[i]  = '0;
          stall_d[i] = 1'b0;
          run_d[i]   = 1'b0;
        end
      end
      if (s4.ctx.in_range) begin
        lock_c  = lock_d[c_addr];
        stop_c  = stop_d[c_addr];
        stall_c = stall_d[c_addr];
        run_c   = run_d[c_addr];
        // opposing-speed count and stall latch
        if (s4.ctx.item.run_active && cfg_q.lock_enable) begin
          if (opposing && lock_c != '1) lock_c = lock_c + 1'b1;
          if (lock_c > cfg_q.lock_limit) begin
            stall_c   = 1'b1;
            applied_c = '0;
            stop_c    = '0;
            lock_c    = '0;
            run_c     = 1'b0;
          end
        end
        // applied speed, zero once stalled
        speed_c  = stall_c ? '0 : cmd;
        fprod_c  = stall_c ? '0 : s4.fprod;
        update_c = applied_c != speed_c;
        if (speed_c != '0) run_c = 1'b1;
        // zero-frequency count drops the running flag
        if (fprod_c == '0) begin
          if (stop_c != '1) stop_c = stop_c + 1'b1;
        end else begin
          stop_c = '0;
        end
        if (stop_c > cfg_q.stop_limit) begin
          stop_c = cfg_q.stop_limit;
          run_c  = 1'b0;
        end
        lock_d[c_addr]  = lock_c;
        stop_d[c_addr]  = stop_c;
        stall_d[c_addr] = stall_c;
        run_d[c_addr]   = run_c;
      end
      // tick timer, periodic lock count clear
      if (s4.ctx.item.last_of_tick) begin
        if (timer_inc > cfg_q.clear_period) begin
          timer_d = '0;
          for (int i = 0; i < MOTOR_COUNT; i++) lock_d[i] = '0;
        end else begin
          timer_d = timer_inc;
        end
      end
    end
  end

  assign freq_c = (fprod_c[FPROD_W-1:40] != '0) ? '1 : fprod_c[39:16];

  // write back to the state memory
  assign mem_we           = load_out;
  assign wr_addr          = c_addr;
  assign wr_word.position = s4.ctx.item.position;
  assign wr_word.filtered = filt_new;
  assign wr_word.applied  = speed_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q  <= '0;
      stop_q  <= '0;
      stall_q <= '0;
      run_q   <= '0;
      timer_q <= '0;
    end else begin
      lock_q  <= lock_d;
      stop_q  <= stop_d;
      stall_q <= stall_d;
      run_q   <= run_d;
      timer_q <= timer_d;
    end
  end

  // output register
  logic                      out_v_q;
  logic [IDX_FIELD_W-1:0]    motor_out_q;
  logic [FREQ_W-1:0]         freq_q;
  logic                      dir_q;
  logic                      update_q;
  logic                      running_q;
  logic                      stalled_q;
  logic                      any_q;
  logic signed [SPEED_W-1:0] smoothed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      motor_out_q <= s4.ctx.item.motor_index;
      freq_q      <= freq_c;
      dir_q       <= !speed_c[SPEED_W-1];
      update_q    <= update_c;
      running_q   <= run_c;
      stalled_q   <= stall_c;
      any_q       <= |stall_d;
      smoothed_q  <= filt_new;
    end
  end

  assign out_valid_o        = out_v_q;
  assign motor_out_o        = motor_out_q;
  assign step_frequency_o   = freq_q;
  assign direction_o        = dir_q;
  assign frequency_update_o = update_q;
  assign running_o          = running_q;
  assign stalled_o          = stalled_q;
  assign any_stalled_o      = any_q;
  assign smoothed_speed_o   = smoothed_q;

  // the interlock keeps a read from meeting a write to the same entry
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("state memory read and write hit the same motor");

  // a stalled motor reports zero frequency, forward direction, not running
  a_stall_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && stalled_q) |-> (freq_q == '0 && dir_q && !running_q && any_q))
    else $error("stalled motor still driven");

  // a result appears only from a committed last-stage item
  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(stat.busy[PIPE_DEPTH-1] && s4.ctx.in_range))
    else $error("result without a committed transaction");

  // results only name motors that exist
  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (EXT_W'(motor_out_q) < EXT_W'(MOTOR_COUNT)))
    else $error("result for a motor out of range");

endmodule

/* test/stepper_speed_and_stall_supervisor_test.sv */
// stepper_speed_and_stall_supervisor_test: self-checking bench for the speed and stall supervisor
// drives per-motor tick sequences through register settings and checks every result transaction
// depends on sssv_pkg and stepper_speed_and_stall_supervisor
`timescale 1ns / 1ps

module stepper_speed_and_stall_supervisor_test;
  import sssv_pkg::*;

  localparam int unsigned MOTORS          = MOTOR_COUNT_DEF;
  localparam int unsigned MAX_GAP         = 13;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned PHASE_COUNT     = 8;
  localparam longint unsigned CYCLE_LIMIT = 600000;

  // register setting kinds for the named phases, later phases draw random settings
  localparam int PH_DEFAULT = 0;
  localparam int PH_HIGH    = 1;
  localparam int PH_LOW     = 2;
  localparam int PH_STALL   = 3;
  localparam int PH_ODD     = 4;

  // one result transaction
  typedef struct packed {
    logic [IDX_FIELD_W-1:0]    motor;
    logic [FREQ_W-1:0]         freq;
    logic                      dir;
    logic                      upd;
    logic                      running;
    logic                      stalled;
    logic                      any;
    logic signed [SPEED_W-1:0] smoothed;
  } report_t;

  // shadow of the per-motor supervisor state and the reports it owes
  class axis_tracker;
    cfg_t                      cfg;
    logic signed [SPEED_W-1:0] last_pos[MOTORS];
    logic signed [SPEED_W-1:0] filt[MOTORS];
    logic signed [SPEED_W-1:0] applied[MOTORS];
    logic signed [SPEED_W-1:0] prev_applied[MOTORS];
    logic [LOCK_W-1:0]         lock_cnt[MOTORS];
    logic [STOP_W-1:0]         stop_cnt[MOTORS];
    bit                        stall[MOTORS];
    bit                        running[MOTORS];
    logic [TIMER_W-1:0]        timer;
    report_t                   due_reports[$];
    int                        errors;

    function new();
      cfg.steps_per_unit = STEPS_PER_UNIT_RST;
      cfg.speed_scale    = SPEED_SCALE_RST;
      cfg.filter_keep    = FILTER_KEEP_RST;
      cfg.lock_enable    = LOCK_ENABLE_RST;
      cfg.lock_limit     = LOCK_LIMIT_RST;
      cfg.stop_limit     = STOP_LIMIT_RST;
      cfg.clear_period   = CLEAR_PERIOD_RST;
      for (int i = 0; i < MOTORS; i++) begin
        last_pos[i] = '0; filt[i] = '0; applied[i] = '0; prev_applied[i] = '0;
        lock_cnt[i] = '0; stop_cnt[i] = '0; stall[i] = 0; running[i] = 0;
      end
      timer = '0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEPS_PER_UNIT: cfg.steps_per_unit = data[15:0];
        REG_SPEED_SCALE:    cfg.speed_scale    = data;
        REG_FILTER_KEEP:    cfg.filter_keep    = data[8:0];
        REG_LOCK_ENABLE:    cfg.lock_enable    = data[0];
        REG_LOCK_LIMIT:     cfg.lock_limit     = data[7:0];
        REG_STOP_LIMIT:     cfg.stop_limit     = data[3:0];
        REG_CLEAR_PERIOD:   cfg.clear_period   = data[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction

    // advance the shadow by one accepted transaction
    function void take_item(item_t it);
      int unsigned m;
      logic signed [SPEED_W-1:0] d32;
      longint delta, sc, raw, kw, f_old, sum, a, f, speed, mag, prod, freq;
      bit upd, any;
      report_t rep;
      if (it.clear_locks) begin
        for (int i = 0; i < MOTORS; i++) begin
          lock_cnt[i] = '0; stall[i] = 0; running[i] = 0;
        end
      end
      if (it.motor_index < MOTORS) begin
        m = it.motor_index;
        // measured speed, wrapped delta times scale, saturated
        d32 = it.position - last_pos[m];
        delta = d32;
        sc = cfg.speed_scale;
        raw = delta * sc;
        if (raw > 64'sh7FFFFFFF) raw = 64'sh7FFFFFFF;
        if (raw < -64'sh80000000) raw = -64'sh80000000;
        // first-order filter, weight capped at full
        kw = (cfg.filter_keep > FILTER_ONE) ? 256 : cfg.filter_keep;
        f_old = filt[m];
        sum = f_old * kw + raw * (256 - kw);
        filt[m] = 32'(sum >>> 8);
        // opposing-direction count against last tick's applied speed
        if (it.run_active && cfg.lock_enable) begin
          a = applied[m];
          f = filt[m];
          if ((a > 0 && f < 0) || (a < 0 && f > 0)) begin
            if (lock_cnt[m] != 8'hFF) lock_cnt[m] = lock_cnt[m] + 1'b1;
          end
          if (lock_cnt[m] > cfg.lock_limit) begin
            stall[m] = 1; applied[m] = '0; prev_applied[m] = '0;
            stop_cnt[m] = '0; lock_cnt[m] = '0; running[m] = 0;
          end
        end
        last_pos[m] = it.position;
        // applied speed and step frequency
        speed = stall[m] ? 64'sd0 : longint'(it.commanded_speed);
        if (speed != 0) running[m] = 1;
        mag = (speed < 0) ? -speed : speed;
        prod = mag * longint'(cfg.steps_per_unit);
        freq = prod / 65536;
        if (freq > 24'hFFFFFF) freq = 24'hFFFFFF;
        upd = 0;
        a = prev_applied[m];
        if (a != speed) begin
          upd = 1;
          prev_applied[m] = 32'(speed);
        end
        applied[m] = 32'(speed);
        // zero-frequency ticks drop the running flag
        if (prod == 0) begin
          if (stop_cnt[m] != 4'hF) stop_cnt[m] = stop_cnt[m] + 1'b1;
        end else begin
          stop_cnt[m] = '0;
        end
        if (stop_cnt[m] > cfg.stop_limit) begin
          stop_cnt[m] = cfg.stop_limit;
          running[m] = 0;
        end
        any = 0;
        for (int i = 0; i < MOTORS; i++) any |= stall[i];
        rep.motor    = 3'(m);
        rep.freq     = freq[FREQ_W-1:0];
        rep.dir      = (speed >= 0);
        rep.upd      = upd;
        rep.running  = running[m];
        rep.stalled  = stall[m];
        rep.any      = any;
        rep.smoothed = filt[m];
        due_reports.push_back(rep);
      end
      // tick timer clears every lock count when it runs past the period
      if (it.last_of_tick) begin
        timer = timer + 1'b1;
        if (timer > cfg.clear_period) begin
          timer = '0;
          for (int i = 0; i < MOTORS; i++) lock_cnt[i] = '0;
        end
      end
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_report(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        $error("result for motor %0d arrived with nothing outstanding", got.motor);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      check_field("motor_out", want.motor, got.motor);
      check_field("step_frequency", want.freq, got.freq);
      check_field("direction", want.dir, got.dir);
      check_field("frequency_update", want.upd, got.upd);
      check_field("running", want.running, got.running);
      check_field("stalled", want.stalled, got.stalled);
      check_field("any_stalled", want.any, got.any);
      check_field("smoothed_speed", want.smoothed, got.smoothed);
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [IDX_FIELD_W-1:0]    motor_index_i;
  logic signed [SPEED_W-1:0] position_i;
  logic signed [SPEED_W-1:0] commanded_speed_i;
  logic                      run_active_i;
  logic                      last_of_tick_i;
  logic                      clear_locks_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [IDX_FIELD_W-1:0]    motor_out_o;
  logic [FREQ_W-1:0]         step_frequency_o;
  logic                      direction_o;
  logic                      frequency_update_o;
  logic                      running_o;
  logic                      stalled_o;
  logic                      any_stalled_o;
  logic signed [SPEED_W-1:0] smoothed_speed_o;

  axis_tracker axes;
  bit tx_calm, rx_calm, burst_only, long_hold_req;
  int unsigned sent_items;
  longint unsigned cycle_count;

  // per-motor trajectory used to build well-formed ticks
  logic signed [SPEED_W-1:0] trk_pos[MOTORS];
  logic signed [SPEED_W-1:0] trk_vel[MOTORS];
  logic signed [SPEED_W-1:0] trk_cmd[MOTORS];

  stepper_speed_and_stall_supervisor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .motor_index_i      (motor_index_i),
    .position_i         (position_i),
    .commanded_speed_i  (commanded_speed_i),
    .run_active_i       (run_active_i),
    .last_of_tick_i     (last_of_tick_i),
    .clear_locks_i      (clear_locks_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .motor_out_o        (motor_out_o),
    .step_frequency_o   (step_frequency_o),
    .direction_o        (direction_o),
    .frequency_update_o (frequency_update_o),
    .running_o          (running_o),
    .stalled_o          (stalled_o),
    .any_stalled_o      (any_stalled_o),
    .smoothed_speed_o   (smoothed_speed_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sample both channels at the rising edge, inputs before results
  always @(posedge clk_i) begin : watch
    item_t seen;
    report_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen.motor_index     = motor_index_i;
        seen.position        = position_i;
        seen.commanded_speed = commanded_speed_i;
        seen.run_active      = run_active_i;
        seen.last_of_tick    = last_of_tick_i;
        seen.clear_locks     = clear_locks_i;
        axes.take_item(seen);
      end
      if (out_valid_o && !out_stall_i) begin
        got.motor    = motor_out_o;
        got.freq     = step_frequency_o;
        got.dir      = direction_o;
        got.upd      = frequency_update_o;
        got.running  = running_o;
        got.stalled  = stalled_o;
        got.any      = any_stalled_o;
        got.smoothed = smoothed_speed_o;
        axes.compare_report(got);
      end
    end
  end

  // result side: random stall before each transaction, one long hold on request
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 0;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic int unsigned next_gap();
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    return (burst_only || tx_calm) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [SPEED_W-1:0] pick_speed();
    int v;
    v = $urandom_range(1, 32'h3FFFF);
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 32'sh7FFFFFFF;
      3:       return 32'sh80000000;
      4, 5:    return $urandom_range(0, 1) ? v : -v;
      6:       return $urandom_range(0, 1) ? 1 : -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [SPEED_W-1:0] pick_step();
    int v;
    v = $urandom_range(1, 40);
    case ($urandom_range(0, 5))
      0:       return '0;
      1, 2:    return $urandom_range(0, 1) ? v : -v;
      3, 4:    return $urandom_range(0, 1) ? v * 50 : -v * 50;
      default: return $urandom;
    endcase
  endfunction

  // offer one input transaction and wait for it to be taken
  task automatic send_item(input logic [IDX_FIELD_W-1:0] m, input logic signed [SPEED_W-1:0] pos,
                           input logic signed [SPEED_W-1:0] cmd, input bit run, input bit last,
                           input bit clr);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    motor_index_i     = m;
    position_i        = pos;
    commanded_speed_i = cmd;
    run_active_i      = run;
    last_of_tick_i    = last;
    clear_locks_i     = clr;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  // one control tick over all motors, with noise and dropped items mixed in
  task automatic run_tick();
    int unsigned m;
    int jitter;
    bit trailing;
    logic signed [SPEED_W-1:0] mag;
    trailing = ($urandom_range(0, 14) == 0);
    for (m = 0; m < MOTORS; m++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(3'($urandom_range(0, 7)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                  1'b0, 1'b0);
      if ($urandom_range(0, 24) == 0) continue;
      if ($urandom_range(0, 9) == 0) trk_cmd[m] = pick_speed();
      if ($urandom_range(0, 11) == 0) begin
        trk_vel[m] = pick_step();
        // often move against the command to provoke a stall
        if ($urandom_range(0, 4) < 2) begin
          mag = (trk_vel[m] < 0) ? -trk_vel[m] : trk_vel[m];
          if (trk_cmd[m] > 0) trk_vel[m] = -mag;
          else if (trk_cmd[m] < 0) trk_vel[m] = mag;
        end
      end
      jitter = $urandom_range(0, 2);
      trk_pos[m] = trk_pos[m] + trk_vel[m] + jitter - 1;
      send_item(3'(m), trk_pos[m], trk_cmd[m], $urandom_range(0, 15) != 0,
                (m == MOTORS - 1) && !trailing, $urandom_range(0, 79) == 0);
    end
    // tick closed by an out-of-range motor instead
    if (trailing)
      send_item(3'($urandom_range(MOTORS, 7)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                1'b1, $urandom_range(0, 3) == 0);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    axes.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_STEPS_PER_UNIT, 32'(c.steps_per_unit));
    write_reg(REG_SPEED_SCALE, c.speed_scale);
    write_reg(REG_FILTER_KEEP, 32'(c.filter_keep));
    write_reg(REG_LOCK_ENABLE, 32'(c.lock_enable));
    write_reg(REG_LOCK_LIMIT, 32'(c.lock_limit));
    write_reg(REG_STOP_LIMIT, 32'(c.stop_limit));
    write_reg(REG_CLEAR_PERIOD, 32'(c.clear_period));
  endtask

  // drop valid, let every result drain, then cover items that give none
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (axes.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic cfg_t phase_settings(int p);
    cfg_t c;
    c.steps_per_unit = STEPS_PER_UNIT_RST;
    c.speed_scale    = SPEED_SCALE_RST;
    c.filter_keep    = FILTER_KEEP_RST;
    c.lock_enable    = LOCK_ENABLE_RST;
    c.lock_limit     = LOCK_LIMIT_RST;
    c.stop_limit     = STOP_LIMIT_RST;
    c.clear_period   = CLEAR_PERIOD_RST;
    case (p)
      PH_DEFAULT: ;
      PH_HIGH: begin
        c.steps_per_unit = 16'hFFFF; c.speed_scale = 32'hFFFFFFFF; c.filter_keep = FILTER_ONE;
        c.lock_enable = 1'b1; c.lock_limit = 8'hFF; c.stop_limit = 4'hF;
        c.clear_period = 16'hFFFF;
      end
      PH_LOW: begin
        c.steps_per_unit = 16'd1; c.speed_scale = '0; c.filter_keep = '0;
        c.lock_enable = 1'b1; c.lock_limit = 8'd1; c.stop_limit = 4'd1; c.clear_period = 16'd1;
      end
      PH_STALL: begin
        c.filter_keep = '0; c.lock_limit = 8'd2; c.stop_limit = 4'd3; c.clear_period = 16'd100;
      end
      // weight above full, timer clearing every tick, detection off
      PH_ODD: begin
        c.filter_keep = 9'd511; c.clear_period = '0; c.lock_enable = 1'b0;
      end
      default: begin
        c.steps_per_unit = 16'($urandom_range(0, 3) == 0 ? $urandom_range(1, 16'hFFFF)
                                                         : $urandom_range(1, 400));
        c.speed_scale    = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 200000);
        c.filter_keep    = 9'($urandom_range(0, 256));
        c.lock_enable    = $urandom_range(0, 3) != 0;
        c.lock_limit     = 8'($urandom_range(0, 3) == 0 ? $urandom_range(1, 255)
                                                        : $urandom_range(1, 6));
        c.stop_limit     = 4'($urandom_range(1, 15));
        c.clear_period   = 16'($urandom_range(0, 1) ? $urandom_range(1, 20)
                                                    : $urandom_range(1, 16'hFFFF));
      end
    endcase
    return c;
  endfunction

  // main sequence
  initial begin
    int unsigned phase_start;
    axes = new();
    cycle_count = 0;
    sent_items = 0;
    tx_calm = 0; rx_calm = 0; burst_only = 0; long_hold_req = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_STEPS_PER_UNIT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    motor_index_i = '0;
    position_i = '0;
    commanded_speed_i = '0;
    run_active_i = 1'b0;
    last_of_tick_i = 1'b0;
    clear_locks_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, wrapping deltas, tiny speeds, out-of-range motors, clears
    send_item(3'd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b0);
    send_item(3'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b0, 1'b0);
    send_item(3'd0, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0, 1'b0);
    send_item(3'd0, 32'sd0, 32'sh80000000, 1'b1, 1'b0, 1'b0);
    send_item(3'd1, -32'sd1, -32'sd1, 1'b1, 1'b0, 1'b0);
    send_item(3'd1, -32'sd1, -32'sd1, 1'b1, 1'b0, 1'b0);
    send_item(3'd2, 32'sd12345, 32'sd65536, 1'b0, 1'b0, 1'b0);
    send_item(3'd3, 32'sh80000000, 32'sd1, 1'b1, 1'b0, 1'b0);
    send_item(3'd4, 32'sh7FFFFFFF, 32'sd0, 1'b1, 1'b1, 1'b0);
    send_item(3'd5, 32'sd1, 32'sd1, 1'b1, 1'b0, 1'b1);
    send_item(3'd6, -32'sd1, -32'sd1, 1'b1, 1'b1, 1'b0);
    send_item(3'd7, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, 1'b1, 1'b1);
    send_item(3'd4, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b1);
    send_item(3'd2, 32'sd12345, -32'sd65536, 1'b1, 1'b0, 1'b0);
    send_item(3'd3, 32'sd0, 32'sh7FFFFFFF, 1'b1, 1'b1, 1'b0);
    wait_idle();

    for (int i = 0; i < MOTORS; i++) begin
      trk_pos[i] = $urandom;
      trk_vel[i] = pick_step();
      trk_cmd[i] = pick_speed();
    end

    // random ticks under a range of register settings
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p != PH_DEFAULT) load_settings(phase_settings(p));
      phase_start = sent_items;
      if (p == PH_STALL) begin
        // hold results back while the sender keeps pushing
        burst_only = 1;
        long_hold_req = 1;
        repeat (12) run_tick();
        burst_only = 0;
      end
      while (sent_items - phase_start < ITEMS_PER_PHASE) run_tick();
      wait_idle();
    end

    if (axes.errors == 0 && axes.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
